[hw/rtl/fiq8_pkg.sv]
package fiq8_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned Lanes = 4;
  localparam int unsigned Stages = 4;

  localparam logic CfgIdxScale = 1'b0;
  localparam logic CfgIdxOrder = 1'b1;

  localparam logic [ByteW-1:0] ByteMin = 8'h80;
  localparam logic [ByteW-1:0] ByteMax = 8'h7F;

  // product after the multiplier stage, before rounding to single
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic signed [10:0] exp;   // unbiased exponent of bit 47 of mant
    logic [47:0] mant;
  } prod_t;

  // rounded single value reduced to what the integer conversion needs
  typedef struct packed {
    logic        special;      // NaN, infinity or beyond 32-bit range
    logic        sign;
    logic signed [10:0] exp;   // unbiased exponent of bit 23 of sig
    logic [23:0] sig;
  } rsgl_t;

endpackage

[hw/rtl/fiq8_lane.sv]
module fiq8_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] val_bits,
  input  logic [31:0] scale_bits,
  output logic [7:0]  byte_out
);

  fiq8_pkg::prod_t p_r, p_nxt;
  fiq8_pkg::rsgl_t s_r, s_nxt;
  logic [7:0] byte_r, byte_nxt;

  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        za, zb, ia, ib, na, nb;
  logic signed [10:0] eu_a, eu_b;

  always_comb begin
    ea = val_bits[30:23];
    eb = scale_bits[30:23];
    ma = {(ea != 8'd0), val_bits[22:0]};
    mb = {(eb != 8'd0), scale_bits[22:0]};
    za = (ea == 8'd0) && (val_bits[22:0] == 23'd0);
    zb = (eb == 8'd0) && (scale_bits[22:0] == 23'd0);
    ia = (ea == 8'hFF) && (val_bits[22:0] == 23'd0);
    ib = (eb == 8'hFF) && (scale_bits[22:0] == 23'd0);
    na = (ea == 8'hFF) && (val_bits[22:0] != 23'd0);
    nb = (eb == 8'hFF) && (scale_bits[22:0] != 23'd0);
    eu_a = (ea == 8'd0) ? -11'sd126 : $signed({3'b000, ea}) - 11'sd127;
    eu_b = (eb == 8'd0) ? -11'sd126 : $signed({3'b000, eb}) - 11'sd127;
    p_nxt.nan  = na || nb || (ia && zb) || (ib && za);
    p_nxt.inf  = ia || ib;
    p_nxt.zero = za || zb;
    p_nxt.sign = val_bits[31] ^ scale_bits[31];
    p_nxt.exp  = eu_a + eu_b + 11'sd1;
    p_nxt.mant = ma * mb;
  end

  // normalise and round the product to single precision
  logic [5:0]  lz;
  logic [47:0] nm;
  logic signed [10:0] ne;
  logic [5:0]  sh;
  logic [48:0] wide;
  logic [23:0] kept;
  logic        g, st;
  logic [24:0] rnd;
  logic signed [10:0] re;

  always_comb begin
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (p_r.mant[i]) lz = 6'(47 - i);
    end
    ne = p_r.exp - 11'(lz);
    sh = lz;
    // subnormal result range: keep exponent at -126
    if (ne < -11'sd126) begin
      if (p_r.exp < -11'sd126) begin
        sh = 6'd0;
      end else begin
        sh = 6'(p_r.exp + 11'sd126);
      end
      ne = -11'sd126;
    end
    nm = p_r.mant << sh;
    wide = {nm, 1'b0};
    if (p_r.exp < -11'sd126) begin
      wide = ({nm, 1'b0} >> 6'(-11'sd126 - p_r.exp > 11'sd48 ? 11'sd48
                                  : -11'sd126 - p_r.exp)) |
             49'((|(({nm, 1'b0}) & ~(49'h1_FFFF_FFFF_FFFF <<
                 6'(-11'sd126 - p_r.exp > 11'sd48 ? 11'sd48 : -11'sd126 - p_r.exp)))));
    end
    kept = wide[48:25];
    g    = wide[24];
    st   = |wide[23:0];
    rnd  = {1'b0, kept} + 25'(g && (st || kept[0]));
    re   = ne;
    if (rnd[24]) begin
      rnd = rnd >> 1;
      re  = ne + 11'sd1;
    end
    s_nxt.sign    = p_r.sign;
    s_nxt.sig     = rnd[23:0];
    s_nxt.exp     = re;
    s_nxt.special = p_r.nan || (p_r.inf && !p_r.zero) ||
                    (!p_r.zero && p_r.mant != 48'd0 && re >= 11'sd31 &&
                     !(p_r.sign && re == 11'sd31 && rnd[22:0] == 23'd0));
    if (p_r.zero || p_r.mant == 48'd0) begin
      s_nxt.sig = 24'd0;
      s_nxt.exp = -11'sd126;
    end
  end

  // integer conversion, ties to even, then saturate
  logic [31:0] ip;
  logic [32:0] fx;
  logic        gb, sb;
  logic [8:0]  mag;

  always_comb begin
    byte_nxt = fiq8_pkg::ByteMin;
    ip = '0; fx = '0; gb = 1'b0; sb = 1'b0; mag = '0;
    if (s_r.special) begin
      byte_nxt = fiq8_pkg::ByteMin;
    end else if (s_r.exp >= 11'sd8) begin
      byte_nxt = s_r.sign ? fiq8_pkg::ByteMin : fiq8_pkg::ByteMax;
    end else begin
      // fixed point value with 25 fraction bits after the binary point
      if (s_r.exp < -11'sd2) begin
        gb = 1'b0;
        sb = s_r.sig != 24'd0;
        ip = '0;
      end else begin
        fx = 33'(s_r.sig) << 6'(s_r.exp + 11'sd2);
        ip = 32'(fx[32:25]);
        gb = fx[24];
        sb = |fx[23:0];
      end
      mag = 9'(ip) + 9'(gb && (sb || ip[0]));
      if (!s_r.sign) begin
        byte_nxt = (mag > 9'd127) ? fiq8_pkg::ByteMax : mag[7:0];
      end else begin
        byte_nxt = (mag > 9'd128) ? fiq8_pkg::ByteMin : 8'(-mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= p_nxt;
      s_r    <= s_nxt;
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;

endmodule

[hw/rtl/float_iq_to_int8_packer.sv]
// Converts two complex samples (four IEEE singles I0,Q0,I1,Q1) per transfer
// into one word of four saturated signed bytes. One item per cycle; results
// pass through the multiply, round to single, convert and saturate, and pack
// stages, and the pipeline holds under back-pressure.
module float_iq_to_int8_packer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // real_first, imag_first, real_second, imag_second
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // packed_word
  output logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);

  logic [31:0] scale_r;
  logic        order_r;
  logic [fiq8_pkg::Stages-1:0] vld_r, vld_nxt;
  logic        en;
  logic [7:0]  b [fiq8_pkg::Lanes];
  logic [31:0] out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 32'h42FE0000;
      order_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fiq8_pkg::CfgIdxScale: scale_r <= cfg_wdata;
        fiq8_pkg::CfgIdxOrder: order_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  for (genvar k = 0; k < fiq8_pkg::Lanes; k++) begin : g_lane
    fiq8_lane u_lane (
      .clk       (clk),
      .en        (en),
      .val_bits  (in_tdata[32*k +: 32]),
      .scale_bits(scale_r),
      .byte_out  (b[k])
    );
  end

  always_comb begin
    vld_nxt = {vld_r[fiq8_pkg::Stages-2:0], in_tvalid};
    out_nxt = order_r ? {b[0], b[1], b[2], b[3]} : {b[3], b[2], b[1], b[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = vld_r[fiq8_pkg::Stages-1];
  assign out_tdata  = out_r;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("stalled with empty output");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    en && !vld_r[fiq8_pkg::Stages-2] |=> !out_tvalid)
    else $error("result invented");
`endif

endmodule
